@@ hw/rtl/epoch_seconds_to_cp56_calendar_defines.svh @@
// Assertion macros shared by the calendar converter.
`ifndef EPOCH_SECONDS_TO_CP56_CALENDAR_DEFINES_SVH
`define EPOCH_SECONDS_TO_CP56_CALENDAR_DEFINES_SVH

// Implication checked on every clock edge outside reset.
`define ESC_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Implication checked on every clock edge, reset included.
`define ESC_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

@@ hw/rtl/esc_pkg.sv @@
// ----------------------------------------------------------------------------
// esc_pkg
// Types, constants and small helpers for the epoch to CP56 calendar converter.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package esc_pkg;

    localparam int unsigned SecsPerDay  = 86400;
    localparam int unsigned SecsPerHour = 3600;
    localparam int unsigned MsPerSec    = 1000;
    localparam int unsigned DaysW       = 16;
    localparam int unsigned TodW        = 17;

    // Days from 1970-01-01 to 1 January of year 1970+k, for k = 0..137.
    localparam int unsigned NumYears    = 138;

    typedef logic [DaysW-1:0] t_days;
    typedef logic [TodW-1:0]  t_tod;

    function automatic logic is_leap(input logic [11:0] year);
        logic l4, l100, l400;
        begin
            l4   = (year[1:0] == 2'd0);
            l100 = (year % 12'd100) == 12'd0;
            l400 = (year % 12'd400) == 12'd0;
            return (l4 && !l100) || l400;
        end
    endfunction

    function automatic t_days year_start(input logic [7:0] k);
        int unsigned d;
        int unsigned y;
        begin
            d = 0;
            for (y = 1970; y < 2108; y++) begin
                if (y - 1970 < k) begin
                    d = d + (is_leap(12'(y)) ? 366 : 365);
                end
            end
            return t_days'(d);
        end
    endfunction

    // Since 8 is 1 modulo 7, summing the octal digits keeps the residue.
    function automatic logic [2:0] mod7(input t_days d);
        logic [5:0] s1;
        logic [3:0] s2;
        begin
            s1 = 6'(d[2:0]) + 6'(d[5:3]) + 6'(d[8:6]) + 6'(d[11:9])
               + 6'(d[14:12]) + 6'(d[15]);
            s2 = 4'(s1[5:3]) + 4'(s1[2:0]);
            return (s2 >= 4'd7) ? 3'(s2 - 4'd7) : 3'(s2);
        end
    endfunction

    function automatic logic [8:0] month_start(input logic [3:0] m, input logic leap);
        logic [8:0] s;
        begin
            case (m)
                4'd1:    s = 9'd0;
                4'd2:    s = 9'd31;
                4'd3:    s = 9'd59;
                4'd4:    s = 9'd90;
                4'd5:    s = 9'd120;
                4'd6:    s = 9'd151;
                4'd7:    s = 9'd181;
                4'd8:    s = 9'd212;
                4'd9:    s = 9'd243;
                4'd10:   s = 9'd273;
                4'd11:   s = 9'd304;
                4'd12:   s = 9'd334;
                default: s = 9'd0;
            endcase
            if (leap && m > 4'd2) begin
                s = s + 9'd1;
            end
            return s;
        end
    endfunction

    function automatic logic [2:0] weekday_of(input logic [2:0] r);
        logic [2:0] w;
        begin
            case (r)
                3'd0:    w = 3'd4;
                3'd1:    w = 3'd5;
                3'd2:    w = 3'd6;
                3'd3:    w = 3'd7;
                3'd4:    w = 3'd1;
                3'd5:    w = 3'd2;
                3'd6:    w = 3'd3;
                default: w = 3'd1;
            endcase
            return w;
        end
    endfunction

endpackage

@@ hw/rtl/esc_split.sv @@
// ----------------------------------------------------------------------------
// esc_split
// Splits seconds into day count and time of day by a reciprocal multiply.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module esc_split (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_en,
    input  logic                 i_valid,
    input  logic [31:0]          i_secs,
    output logic                 o_valid,
    output esc_pkg::t_days       o_days,
    output esc_pkg::t_tod        o_tod
);
    import esc_pkg::*;

    // floor(x/86400) = (x * M) >> 48 estimate, corrected by one compare.
    localparam logic [31:0] Recip = 32'(64'(1) * (2**48) / SecsPerDay);

    logic             r_v1, r_v2;
    logic [31:0]      r_secs1;
    logic [63:0]      r_prod;
    t_days            r_days;
    t_tod             r_tod;
    logic [33:0]      w_rem;
    t_days            w_q;

    assign w_q   = t_days'(r_prod[63:48]);
    assign w_rem = 34'(r_secs1) - 34'(w_q) * 34'(SecsPerDay);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else if (i_en) begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_secs1 <= i_secs;
            r_prod  <= 64'(i_secs) * 64'(Recip);
            if (w_rem >= 34'(SecsPerDay)) begin
                r_days <= w_q + t_days'(1);
                r_tod  <= t_tod'(w_rem - 34'(SecsPerDay));
            end else begin
                r_days <= w_q;
                r_tod  <= t_tod'(w_rem);
            end
        end
    end

    assign o_valid = r_v2;
    assign o_days  = r_days;
    assign o_tod   = r_tod;
endmodule

@@ hw/rtl/esc_date.sv @@
// ----------------------------------------------------------------------------
// esc_date
// Finds year, month, day and weekday from the day count, and hour, minute
// and second from the time of day, in three register stages.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module esc_date (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_en,
    input  logic                 i_valid,
    input  esc_pkg::t_days       i_days,
    input  esc_pkg::t_tod        i_tod,
    output logic                 o_valid,
    output logic [15:0]          o_milliseconds,
    output logic [5:0]           o_minute,
    output logic [4:0]           o_hour,
    output logic [2:0]           o_weekday,
    output logic [4:0]           o_day_of_month,
    output logic [3:0]           o_month,
    output logic [6:0]           o_year_code
);
    import esc_pkg::*;

    logic       r_v1, r_v2, r_v3;
    // Stage 1: year index, hour, weekday.
    logic [7:0] r_k;
    t_days      r_days1;
    logic [4:0] r_hour1;
    logic [11:0] r_rem1;
    logic [2:0] r_wd1;
    // Stage 2: day of year, minute, second.
    logic [8:0] r_doy;
    logic       r_leap;
    logic [7:0] r_k2;
    logic [4:0] r_hour2;
    logic [5:0] r_min2, r_sec2;
    logic [2:0] r_wd2;
    // Stage 3: outputs.
    logic [15:0] r_ms;
    logic [5:0]  r_min3;
    logic [4:0]  r_hour3, r_dom;
    logic [2:0]  r_wd3;
    logic [3:0]  r_mon;
    logic [6:0]  r_yc;

    logic [7:0]  w_k;
    t_days       w_ys;
    logic [4:0]  w_hour;
    logic [2:0]  w_wd;
    logic [5:0]  w_min;
    logic [11:0] w_y;
    logic [3:0]  w_m;
    logic [8:0]  w_ms;

    always_comb begin
        w_k  = 8'd0;
        w_ys = t_days'(0);
        for (int j = 1; j < NumYears; j++) begin
            if (i_days >= year_start(8'(j))) begin
                w_k  = 8'(j);
                w_ys = year_start(8'(j));
            end
        end
        w_hour = 5'd0;
        for (int h = 1; h < 24; h++) begin
            if (i_tod >= t_tod'(h * SecsPerHour)) begin
                w_hour = 5'(h);
            end
        end
        w_wd = weekday_of(mod7(i_days));
    end

    always_comb begin
        w_min = 6'd0;
        for (int n = 1; n < 60; n++) begin
            if (r_rem1 >= 12'(n * 60)) begin
                w_min = 6'(n);
            end
        end
        w_y = 12'd1970 + 12'(r_k2);
        w_m = 4'd1;
        for (int m = 2; m <= 12; m++) begin
            if (r_doy >= month_start(4'(m), r_leap)) begin
                w_m = 4'(m);
            end
        end
        w_ms = month_start(w_m, r_leap);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else if (i_en) begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_k     <= w_k;
            r_days1 <= i_days - w_ys;
            r_hour1 <= w_hour;
            r_rem1  <= 12'(i_tod - t_tod'(32'(w_hour) * SecsPerHour));
            r_wd1   <= w_wd;

            r_doy   <= 9'(r_days1);
            // From 1970 to 2107 the only century year that is not leap is 2100.
            r_leap  <= (r_k[1:0] == 2'd2) && (r_k != 8'd130);
            r_k2    <= r_k;
            r_hour2 <= r_hour1;
            r_min2  <= w_min;
            r_sec2  <= 6'(r_rem1 - 12'(w_min) * 12'd60);
            r_wd2   <= r_wd1;

            r_ms    <= 16'(r_sec2) * 16'(MsPerSec);
            r_min3  <= r_min2;
            r_hour3 <= r_hour2;
            r_wd3   <= r_wd2;
            r_mon   <= w_m;
            r_dom   <= 5'(r_doy - w_ms + 9'd1);
            r_yc    <= (w_y >= 12'd2000) ? 7'(w_y - 12'd2000) : 7'(r_k2);
        end
    end

    assign o_valid        = r_v3;
    assign o_milliseconds = r_ms;
    assign o_minute       = r_min3;
    assign o_hour         = r_hour3;
    assign o_weekday      = r_wd3;
    assign o_day_of_month = r_dom;
    assign o_month        = r_mon;
    assign o_year_code    = r_yc;

`include "epoch_seconds_to_cp56_calendar_defines.svh"

    `ESC_ASSERT(a_month_range, i_clk, i_rst_n, r_v3 |-> (r_mon >= 4'd1 && r_mon <= 4'd12), "month out of range")
    `ESC_ASSERT(a_dom_range, i_clk, i_rst_n, r_v3 |-> (r_dom >= 5'd1 && r_dom <= 5'd31), "day out of range")
    `ESC_ASSERT(a_hour_range, i_clk, i_rst_n, r_v3 |-> (r_hour3 <= 5'd23 && r_min3 <= 6'd59), "time out of range")
endmodule

@@ hw/rtl/epoch_seconds_to_cp56_calendar.sv @@
// ----------------------------------------------------------------------------
// epoch_seconds_to_cp56_calendar
// Converts seconds since 1970 into CP56Time2a calendar fields.
// ----------------------------------------------------------------------------
// Channel  | Direction | Handshake          | Payload
// input    | in        | i_valid / o_ready  | i_epoch_seconds
// result   | out       | o_valid / i_ready  | o_milliseconds .. o_year_code
//
// The day split multiply has two register stages and the date part three.
// One transfer can enter every cycle while the output is not stalled; the pipeline advances as a whole.
// When the output holds a result not yet taken, the pipeline freezes.
// Reset clears every valid bit; data registers are not reset.
`timescale 1ns / 1ps

module epoch_seconds_to_cp56_calendar (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [31:0] i_epoch_seconds,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [15:0] o_milliseconds,
    output logic [5:0]  o_minute,
    output logic [4:0]  o_hour,
    output logic [2:0]  o_weekday,
    output logic [4:0]  o_day_of_month,
    output logic [3:0]  o_month,
    output logic [6:0]  o_year_code
);
    import esc_pkg::*;

    logic  w_en;
    logic  w_sv;
    t_days w_days;
    t_tod  w_tod;

    assign w_en    = !o_valid || i_ready;
    assign o_ready = w_en;

    esc_split u_split (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (i_valid),
        .i_secs  (i_epoch_seconds),
        .o_valid (w_sv),
        .o_days  (w_days),
        .o_tod   (w_tod)
    );

    esc_date u_date (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_en           (w_en),
        .i_valid        (w_sv),
        .i_days         (w_days),
        .i_tod          (w_tod),
        .o_valid        (o_valid),
        .o_milliseconds (o_milliseconds),
        .o_minute       (o_minute),
        .o_hour         (o_hour),
        .o_weekday      (o_weekday),
        .o_day_of_month (o_day_of_month),
        .o_month        (o_month),
        .o_year_code    (o_year_code)
    );

`include "epoch_seconds_to_cp56_calendar_defines.svh"

    `ESC_ASSERT(a_hold, i_clk, i_rst_n, (o_valid && !i_ready) |=> (o_valid && $stable(o_minute)), "result dropped while stalled")
    `ESC_ASSERT_ALWAYS(a_reset, i_clk, !i_rst_n |=> !o_valid, "valid after reset")
endmodule

@@ tb/epoch_seconds_to_cp56_calendar_checker.sv @@
// ----------------------------------------------------------------------------
// epoch_seconds_to_cp56_calendar_checker
// Watches both channels of the calendar converter, computes the expected
// calendar fields for every accepted timestamp and compares each result.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module epoch_seconds_to_cp56_calendar_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    input  logic        i_ready_in,
    input  logic [31:0] i_epoch_seconds,
    input  logic        i_valid_out,
    input  logic        i_ready,
    input  logic [15:0] i_milliseconds,
    input  logic [5:0]  i_minute,
    input  logic [4:0]  i_hour,
    input  logic [2:0]  i_weekday,
    input  logic [4:0]  i_day_of_month,
    input  logic [3:0]  i_month,
    input  logic [6:0]  i_year_code,
    output int          o_fail_count,
    output int          o_pending,
    output int          o_results_seen
);

    typedef struct packed {
        logic [15:0] milliseconds;
        logic [5:0]  minute;
        logic [4:0]  hour;
        logic [2:0]  weekday;
        logic [4:0]  day_of_month;
        logic [3:0]  month;
        logic [6:0]  year_code;
    } t_calendar;

    t_calendar expected_dates[$];
    int        mismatches;

    function automatic bit leap_year(input int unsigned y);
        return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
    endfunction

    function automatic t_calendar calendar_of(input logic [31:0] secs);
        t_calendar   c;
        int unsigned days, tod, y, m, mlen;
        days = secs / 86400;
        tod  = secs - days * 86400;
        c.hour         = 5'(tod / 3600);
        tod            = tod % 3600;
        c.minute       = 6'(tod / 60);
        c.milliseconds = 16'((tod % 60) * 1000);
        c.weekday      = 3'(((days + 3) % 7) + 1);
        y = 1970;
        while (days >= (leap_year(y) ? 366 : 365)) begin
            days -= leap_year(y) ? 366 : 365;
            y++;
        end
        c.year_code = 7'((y >= 2000) ? y - 2000 : y - 1970);
        m = 1;
        while (m < 12) begin
            case (m)
                2:          mlen = leap_year(y) ? 29 : 28;
                4, 6, 9, 11: mlen = 30;
                default:    mlen = 31;
            endcase
            if (days < mlen) break;
            days -= mlen;
            m++;
        end
        c.month        = 4'(m);
        c.day_of_month = 5'(days + 1);
        return c;
    endfunction

    assign o_fail_count = mismatches;
    assign o_pending    = expected_dates.size();

    always @(posedge i_clk) begin
        t_calendar got, want;
        if (!i_rst_n) begin
            mismatches     <= 0;
            o_results_seen <= 0;
        end else begin
            if (i_valid && i_ready_in) begin
                expected_dates.push_back(calendar_of(i_epoch_seconds));
            end
            if (i_valid_out && i_ready) begin
                got = {i_milliseconds, i_minute, i_hour, i_weekday,
                       i_day_of_month, i_month, i_year_code};
                o_results_seen <= o_results_seen + 1;
                if (expected_dates.size() == 0) begin
                    if (mismatches < 10) $display("Unexpected result transfer: %p", got);
                    mismatches <= mismatches + 1;
                end else begin
                    want = expected_dates.pop_front();
                    if (got !== want) begin
                        if (mismatches < 10) begin
                            $display("Mismatch: expected %p", want);
                            $display("          actual   %p", got);
                        end
                        mismatches <= mismatches + 1;
                    end
                end
            end
        end
    end

endmodule

@@ tb/tb_epoch_seconds_to_cp56_calendar.sv @@
// ----------------------------------------------------------------------------
// tb_epoch_seconds_to_cp56_calendar
// Drives directed and random timestamps into the converter with random gaps
// and output stalls, including one long hold-off, and reports the verdict.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_epoch_seconds_to_cp56_calendar;

    localparam int NumRandom  = 1430;
    localparam int CycleLimit = 200000;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_ready;
    logic [31:0] i_epoch_seconds = '0;
    logic        o_valid;
    logic        i_ready = 1'b0;
    logic [15:0] o_milliseconds;
    logic [5:0]  o_minute;
    logic [4:0]  o_hour;
    logic [2:0]  o_weekday;
    logic [4:0]  o_day_of_month;
    logic [3:0]  o_month;
    logic [6:0]  o_year_code;

    int  fail_count, pending, results_seen, cycles, sent;
    bit  stimulus_done = 1'b0;

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    epoch_seconds_to_cp56_calendar u_dut (.*);

    epoch_seconds_to_cp56_calendar_checker u_checker (
        .i_clk, .i_rst_n, .i_valid, .i_ready_in(o_ready), .i_epoch_seconds,
        .i_valid_out(o_valid), .i_ready, .i_milliseconds(o_milliseconds),
        .i_minute(o_minute), .i_hour(o_hour), .i_weekday(o_weekday),
        .i_day_of_month(o_day_of_month), .i_month(o_month),
        .i_year_code(o_year_code),
        .o_fail_count(fail_count), .o_pending(pending), .o_results_seen(results_seen)
    );

    task automatic send_timestamp(input logic [31:0] secs, input bit gaps);
        int wait_cycles;
        wait_cycles = gaps ? $urandom_range(0, 15) : 0;
        if (wait_cycles > 0) begin
            i_valid <= 1'b0;
            repeat (wait_cycles) @(negedge i_clk);
        end
        i_valid         <= 1'b1;
        i_epoch_seconds <= secs;
        do @(posedge i_clk); while (!o_ready);
        sent++;
        @(negedge i_clk);
    endtask

    function automatic logic [31:0] random_timestamp();
        case ($urandom_range(0, 4))
            0: return $urandom();
            1: return $urandom_range(0, 32'h0FFF_FFFF);
            // Near a New Year.
            2: return 32'd946684800 + $urandom_range(0, 99) * 32'd31557600
                      - $urandom_range(0, 200000);
            3: return 32'hFFFF_FFFF - $urandom_range(0, 40000000);
            default: return $urandom_range(0, 86400 * 400);
        endcase
    endfunction

    initial begin
        logic [31:0] directed[$];
        directed = '{32'd0, 32'd59, 32'd86399, 32'd86400, 32'd951782400,
                     32'd951868800, 32'd946684799, 32'd946684800, 32'd4107456000,
                     32'd4107542399, 32'd4107542400, 32'd4102444800,
                     32'd1700000000, 32'd2147483647, 32'd2147483648,
                     32'hFFFF_FFFF, 32'hAAAA_AAAA, 32'h5555_5555, 32'd1234567890,
                     32'd31535999, 32'd68169600, 32'd3155760000};
        repeat (5) @(negedge i_clk);
        i_rst_n <= 1'b1;
        foreach (directed[k]) send_timestamp(directed[k], k % 2 == 1);
        for (int k = 0; k < NumRandom; k++) begin
            send_timestamp(random_timestamp(), k % 200 < 150);
        end
        i_valid <= 1'b0;
        stimulus_done = 1'b1;
    end

    // Receiver: random stalls, with one long hold-off while items keep coming.
    initial begin
        int stall;
        bit long_hold_done;
        long_hold_done = 1'b0;
        @(posedge i_rst_n);
        @(negedge i_clk);
        while (1) begin
            if (!long_hold_done && sent >= 300) begin
                long_hold_done = 1'b1;
                i_ready <= 1'b0;
                repeat (200) @(negedge i_clk);
            end
            stall = (results_seen % 300 < 200) ? $urandom_range(0, 15) : 0;
            if (stall > 0) begin
                i_ready <= 1'b0;
                repeat (stall) @(negedge i_clk);
            end
            i_ready <= 1'b1;
            @(posedge i_clk);
            if (o_valid) begin
                @(negedge i_clk);
            end else begin
                do @(posedge i_clk); while (!o_valid);
                @(negedge i_clk);
            end
        end
    end

    initial begin
        wait (stimulus_done);
        while (pending != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        $display("Converted %0d timestamps: field extremes, leap days, year 2000/2100,",
                 results_seen);
        $display("the top of the 32-bit range and random gaps and output stalls.");
        if (fail_count == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CycleLimit) begin
            $display("Timeout after %0d cycles.", cycles);
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    initial cycles = 0;

endmodule
